/* src/cpim_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpim_pkg
// shared widths, constants, register map and configuration type of the
// ccd pixel imperfection model
// ----------------------------------------------------------------------------
package cpim_pkg;

	localparam int PIX_W    = 14;
	localparam int REFL_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int REG_W    = 16;
	localparam int LINE_W   = 15;
	localparam int CFG_IDX_W = 4;

	// falloff path
	localparam int DIST_W   = 15;
	localparam int DSQ_W    = 2 * DIST_W;
	localparam int NUM_W    = REG_W + DSQ_W;
	localparam int DIV_BITS = 24;
	localparam int DIVW     = DSQ_W + DIV_BITS;
	localparam int FAC_W    = 25;

	// gain and offset path
	localparam int LR_W   = 2 * REG_W;
	localparam int GAIN_W = 18;
	localparam int OFS_W  = 18;
	localparam int SIG_W  = LR_W + GAIN_W - 16;

	localparam int UNITY_Q16 = 65536;
	localparam int DROP_CAP  = 1 << DIV_BITS;

	localparam logic signed [FAC_W-1:0] FAC_UNITY = FAC_W'(UNITY_Q16);
	localparam logic signed [FAC_W-1:0] FAC_FLOOR = FAC_W'(UNITY_Q16 - DROP_CAP);

	localparam logic [31:0] HASH_C1   = 32'd2654435761;
	localparam logic [31:0] HASH_C2   = 32'd2246822519;
	localparam logic [31:0] HASH_C3   = 32'd3266489917;
	localparam logic [31:0] SALT_GAIN = 32'h9E3779B9;
	localparam logic [31:0] SALT_DARK = 32'h85EBCA6B;

	// pipeline depth
	localparam int PAT_STAGES  = 6;
	localparam int FO_STAGES   = 4 + DIV_BITS + 1;
	localparam int PAT_LAG     = FO_STAGES - PAT_STAGES;
	localparam int MIX_STAGES  = 2;
	localparam int PIPE_STAGES = FO_STAGES + MIX_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_SPREAD     = 4'd0,
		REG_GAIN_EVEN_ODD   = 4'd1,
		REG_DARK_BASE       = 4'd2,
		REG_DARK_SPREAD     = 4'd3,
		REG_OFFSET_EVEN_ODD = 4'd4,
		REG_LAMP_FALLOFF    = 4'd5,
		REG_LAMP_LEVEL      = 4'd6,
		REG_LINE_PIXELS     = 4'd7
	} cpim_reg_t;

	typedef struct packed {
		logic [REG_W-1:0]  gain_spread;
		logic [REG_W-1:0]  gain_even_odd;
		logic [REG_W-1:0]  dark_base;
		logic [REG_W-1:0]  dark_spread;
		logic [REG_W-1:0]  offset_even_odd;
		logic [REG_W-1:0]  lamp_falloff;
		logic [REG_W-1:0]  lamp_level;
		logic [LINE_W-1:0] line_pixels;
	} cpim_cfg_t;

	localparam cpim_cfg_t CFG_RESET = '{
		gain_spread:     16'd0,
		gain_even_odd:   16'd0,
		dark_base:       16'd0,
		dark_spread:     16'd0,
		offset_even_odd: 16'd0,
		lamp_falloff:    16'd0,
		lamp_level:      16'd65535,
		line_pixels:     15'd1024
	};

endpackage
`default_nettype wire

/* src/cpim_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpim channel interfaces
// valid/ready channels for pixel beats in and sample beats out
// ----------------------------------------------------------------------------
interface cpim_pixel_if
	import cpim_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel_index;
	logic [REFL_W-1:0] reflectance;

	modport source (output valid, output pixel_index, output reflectance, input ready);
	modport sink   (input valid, input pixel_index, input reflectance, output ready);
endinterface

interface cpim_sample_if
	import cpim_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* src/cpim_pattern.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpim_pattern
// fixed-pattern hash, per-pixel gain and dark offset, lit signal level;
// results are lagged to line up with the falloff path
// ----------------------------------------------------------------------------
module cpim_pattern
	import cpim_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  cpim_cfg_t         cfg,
	input  logic [PIX_W-1:0]  pixel_index,
	input  logic [REFL_W-1:0] reflectance,
	output logic [SIG_W-1:0]  signal_level,
	output logic [OFS_W-1:0]  offset
);

	typedef struct packed {
		logic [SIG_W-1:0] sig;
		logic [OFS_W-1:0] ofs;
	} lag_t;

	logic [31:0] seed, mix_a, mix_b, xa, xb, ua, ub;
	logic signed [31:0] pat_a, pat_b;
	logic signed [48:0] prod_a, prod_b;
	logic signed [16:0] adj_a, adj_b;
	logic signed [18:0] geo_x, oeo_x, geo_term, oeo_term, gain_raw, ofs_raw;
	logic [49:0] lit_prod;

	logic [31:0] ha_s1, hb_s1, ha_s2, hb_s2, ha_s3, hb_s3;
	logic signed [47:0] pa_s4, pb_s4;
	logic [LR_W-1:0] lr_s1, lr_s2, lr_s3, lr_s4, lr_s5;
	logic even_s1, even_s2, even_s3, even_s4;
	logic [GAIN_W-1:0] gain_s5;
	logic [OFS_W-1:0] ofs_s5;
	lag_t pix_s6;
	lag_t lag_s [PAT_LAG];

	// stage 1: index scramble with the two salts
	assign seed  = 32'(32'(pixel_index) * HASH_C1);
	assign mix_a = seed + SALT_GAIN;
	assign mix_b = seed + SALT_DARK;

	// stage 3 and 4 mixing
	assign xa = ha_s2 ^ (ha_s2 >> 13);
	assign xb = hb_s2 ^ (hb_s2 >> 13);
	assign ua = ha_s3 ^ (ha_s3 >> 16);
	assign ub = hb_s3 ^ (hb_s3 >> 16);
	assign pat_a = $signed({~ua[31], ua[30:0]});
	assign pat_b = $signed({~ub[31], ub[30:0]});
	assign prod_a = $signed({1'b0, cfg.gain_spread}) * pat_a;
	assign prod_b = $signed({1'b0, cfg.dark_spread}) * pat_b;

	// stage 5: floor by 2^31, even/odd delta, clamp at zero
	assign adj_a = pa_s4[47:31];
	assign adj_b = pb_s4[47:31];
	assign geo_x = {{3{cfg.gain_even_odd[15]}}, cfg.gain_even_odd};
	assign oeo_x = {{3{cfg.offset_even_odd[15]}}, cfg.offset_even_odd};
	assign geo_term = even_s4 ? geo_x : -geo_x;
	assign oeo_term = even_s4 ? oeo_x : -oeo_x;
	assign gain_raw = 19'sd65536 + {{2{adj_a[16]}}, adj_a} + geo_term;
	assign ofs_raw  = $signed({3'b000, cfg.dark_base}) + {{2{adj_b[16]}}, adj_b} + oeo_term;

	// stage 6
	assign lit_prod = lr_s5 * gain_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ha_s1   <= mix_a ^ (mix_a >> 15);
			hb_s1   <= mix_b ^ (mix_b >> 15);
			lr_s1   <= cfg.lamp_level * reflectance;
			even_s1 <= ~pixel_index[0];

			ha_s2   <= 32'(ha_s1 * HASH_C2);
			hb_s2   <= 32'(hb_s1 * HASH_C2);
			lr_s2   <= lr_s1;
			even_s2 <= even_s1;

			ha_s3   <= 32'(xa * HASH_C3);
			hb_s3   <= 32'(xb * HASH_C3);
			lr_s3   <= lr_s2;
			even_s3 <= even_s2;

			pa_s4   <= prod_a[47:0];
			pb_s4   <= prod_b[47:0];
			lr_s4   <= lr_s3;
			even_s4 <= even_s3;

			gain_s5 <= gain_raw[18] ? '0 : gain_raw[GAIN_W-1:0];
			ofs_s5  <= ofs_raw[18] ? '0 : ofs_raw[OFS_W-1:0];
			lr_s5   <= lr_s4;

			pix_s6.sig <= lit_prod[49:16];
			pix_s6.ofs <= ofs_s5;

			lag_s[0] <= pix_s6;
			for (int k = 1; k < PAT_LAG; k++) begin
				lag_s[k] <= lag_s[k-1];
			end
		end
	end

	assign signal_level = lag_s[PAT_LAG-1].sig;
	assign offset       = lag_s[PAT_LAG-1].ofs;

endmodule
`default_nettype wire

/* src/cpim_falloff.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpim_falloff
// quadratic lamp falloff: distance from line centre, squared and scaled,
// divided by the squared line length in a restoring divider, one quotient
// bit per stage, capped at 2^24
// ----------------------------------------------------------------------------
module cpim_falloff
	import cpim_pkg::*;
#(
	parameter int unsigned MAX_LINE_PIXELS = 16384
)(
	input  logic                    clk,
	input  logic                    en,
	input  cpim_cfg_t               cfg,
	input  logic [PIX_W-1:0]        pixel_index,
	output logic signed [FAC_W-1:0] factor
);

	logic [16:0] lp_x;
	logic [LINE_W-1:0] len;
	logic [LINE_W:0] diff;
	logic [DIST_W-1:0] span;
	logic cap_now;
	logic [DIVW-1:0] trial [DIV_BITS];
	logic [DIV_BITS-1:0] take;

	logic [DSQ_W-1:0] len_sq_q;
	logic [DIST_W-1:0] dist_s1;
	logic [DSQ_W-1:0] dsq_s2;
	logic [NUM_W-1:0] num_s3;
	logic [NUM_W-1:0] rem_s [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS+1];
	logic [DIV_BITS:0] cap_s;
	logic signed [FAC_W-1:0] factor_s;

	// effective line length
	assign lp_x = {2'b00, cfg.line_pixels};
	always_comb begin
		if (cfg.line_pixels == '0) begin
			len = LINE_W'(1);
		end else if (lp_x > 17'(MAX_LINE_PIXELS)) begin
			len = LINE_W'(MAX_LINE_PIXELS);
		end else begin
			len = cfg.line_pixels;
		end
	end

	// |2*index + 1 - len|
	assign diff = {1'b0, pixel_index, 1'b1} - {1'b0, len};
	assign span = diff[LINE_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

	assign cap_now = DIVW'(num_s3) >= (DIVW'(len_sq_q) << DIV_BITS);

	always_comb begin
		for (int j = 0; j < DIV_BITS; j++) begin
			trial[j] = DIVW'(rem_s[j]) - (DIVW'(len_sq_q) << (DIV_BITS - 1 - j));
			take[j]  = ~trial[j][DIVW-1];
		end
	end

	always_ff @(posedge clk) begin
		len_sq_q <= {{(DSQ_W-LINE_W){1'b0}}, len} * {{(DSQ_W-LINE_W){1'b0}}, len};
		if (en) begin
			dist_s1 <= span;
			dsq_s2  <= {{(DSQ_W-DIST_W){1'b0}}, dist_s1} * {{(DSQ_W-DIST_W){1'b0}}, dist_s1};
			num_s3  <= NUM_W'(cfg.lamp_falloff) * NUM_W'(dsq_s2);

			rem_s[0] <= num_s3;
			quo_s[0] <= '0;
			cap_s[0] <= cap_now;
			for (int j = 0; j < DIV_BITS; j++) begin
				rem_s[j+1] <= take[j] ? trial[j][NUM_W-1:0] : rem_s[j];
				quo_s[j+1] <= {quo_s[j][DIV_BITS-2:0], take[j]};
				cap_s[j+1] <= cap_s[j];
			end

			factor_s <= cap_s[DIV_BITS] ? FAC_FLOOR
				: FAC_UNITY - $signed(FAC_W'(quo_s[DIV_BITS]));
		end
	end

	assign factor = factor_s;

endmodule
`default_nettype wire

/* src/cpim_mix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpim_mix
// applies the falloff factor to the lit level, adds the dark offset and
// saturates to the sample range
// ----------------------------------------------------------------------------
module cpim_mix
	import cpim_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = 16
)(
	input  logic                    clk,
	input  logic                    en,
	input  logic [SIG_W-1:0]        signal_level,
	input  logic [OFS_W-1:0]        offset,
	input  logic signed [FAC_W-1:0] factor,
	output logic [SAMPLE_W-1:0]     sample
);

	localparam int TOT_W = SIG_W + 1 + FAC_W;
	localparam int VAL_W = TOT_W - 32;
	localparam logic signed [VAL_W-1:0] SMAX = VAL_W'((1 << SAMPLE_BITS) - 1);

	logic signed [TOT_W-1:0] prod, total;
	logic signed [VAL_W-1:0] val;

	logic signed [TOT_W-1:0] prod_s1;
	logic [OFS_W-1:0] ofs_s1;
	logic [SAMPLE_W-1:0] sample_s2;

	assign prod  = $signed({1'b0, signal_level}) * factor;
	assign total = prod_s1 + $signed({{(TOT_W-OFS_W-32){1'b0}}, ofs_s1, 32'd0});
	assign val   = total[TOT_W-1:32];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			ofs_s1  <= offset;
			if (val[VAL_W-1]) begin
				sample_s2 <= '0;
			end else if (val > SMAX) begin
				sample_s2 <= SMAX[SAMPLE_W-1:0];
			end else begin
				sample_s2 <= val[SAMPLE_W-1:0];
			end
		end
	end

	assign sample = sample_s2;

endmodule
`default_nettype wire

/* src/ccd_pixel_imperfection_model_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pixel_imperfection_model_unit
// simulated ccd sample from pixel index and reflectance, with fixed-pattern
// gain and dark offset and quadratic lamp falloff
// ----------------------------------------------------------------------------
// The unit takes one pixel beat per clock unless stalled and returns samples in
// order. The depth is set by the falloff path: a 24-stage restoring divider,
// one quotient bit per stage, between four stages of distance and scaling and
// one factor stage, followed by two stages of mixing and saturation; the gain
// and offset path is lagged to meet it. Input ready is registered; a one-beat
// skid register behind the pipeline absorbs a stall of the output, and the
// pipeline freezes while it is full. Configuration must be written through the
// register port only while no beat is in flight; the unit does not enforce it.
// ----------------------------------------------------------------------------
module ccd_pixel_imperfection_model_unit
	import cpim_pkg::*;
#(
	parameter int unsigned MAX_LINE_PIXELS = 16384,
	parameter int unsigned SAMPLE_BITS     = 16
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	cpim_pixel_if.sink           pixel,
	cpim_sample_if.source        result
);

	cpim_cfg_t cfg_q;
	logic [PIPE_STAGES-1:0] vld_s;
	logic skid_vld_q;
	logic [SAMPLE_W-1:0] skid_sample_q;

	logic adv;
	logic pipe_vld;
	logic [SIG_W-1:0] signal_level;
	logic [OFS_W-1:0] offset;
	logic signed [FAC_W-1:0] factor;
	logic [SAMPLE_W-1:0] pipe_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cpim_reg_t'(cfg_index))
			REG_GAIN_SPREAD:     cfg_q.gain_spread     <= cfg_wdata;
			REG_GAIN_EVEN_ODD:   cfg_q.gain_even_odd   <= cfg_wdata;
			REG_DARK_BASE:       cfg_q.dark_base       <= cfg_wdata;
			REG_DARK_SPREAD:     cfg_q.dark_spread     <= cfg_wdata;
			REG_OFFSET_EVEN_ODD: cfg_q.offset_even_odd <= cfg_wdata;
			REG_LAMP_FALLOFF:    cfg_q.lamp_falloff    <= cfg_wdata;
			REG_LAMP_LEVEL:      cfg_q.lamp_level      <= cfg_wdata;
			REG_LINE_PIXELS:     cfg_q.line_pixels     <= cfg_wdata[LINE_W-1:0];
			default: ;
			endcase
		end
	end

	cpim_pattern u_pattern (
		.clk          (clk),
		.en           (adv),
		.cfg          (cfg_q),
		.pixel_index  (pixel.pixel_index),
		.reflectance  (pixel.reflectance),
		.signal_level (signal_level),
		.offset       (offset)
	);

	cpim_falloff #(
		.MAX_LINE_PIXELS (MAX_LINE_PIXELS)
	) u_falloff (
		.clk         (clk),
		.en          (adv),
		.cfg         (cfg_q),
		.pixel_index (pixel.pixel_index),
		.factor      (factor)
	);

	cpim_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk          (clk),
		.en           (adv),
		.signal_level (signal_level),
		.offset       (offset),
		.factor       (factor),
		.sample       (pipe_sample)
	);

	assign adv           = ~skid_vld_q;
	assign pipe_vld      = vld_s[PIPE_STAGES-1];
	assign pixel.ready   = adv;
	assign result.valid  = skid_vld_q | pipe_vld;
	assign result.sample = skid_vld_q ? skid_sample_q : pipe_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s      <= '0;
			skid_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s      <= {vld_s[PIPE_STAGES-2:0], pixel.valid};
			skid_vld_q <= pipe_vld & ~result.ready;
		end else if (result.ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	// last beat parked when the output stalls
	always_ff @(posedge clk) begin
		if (adv) begin
			skid_sample_q <= pipe_sample;
		end
	end

`ifndef SYNTHESIS
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(pipe_vld && !result.ready))
		else $error("skid filled without a stalled beat");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !result.ready) |=> (skid_vld_q && $stable(skid_sample_q)))
		else $error("parked beat lost or changed");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && result.ready) |=> !skid_vld_q)
		else $error("parked beat repeated");

	a_pipe_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(vld_s))
		else $error("pipeline moved while skid full");
`endif

endmodule
`default_nettype wire
